>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 RGB box blur: pixel and result
// words, pipeline control, channel sums and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 12;   // nine 8-bit samples sum to at most 2295
   localparam int POS_W      = 11;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 4'd1;

   // floor(x / 9) == (x * 7282) >> 16 for every x below 32768
   localparam logic [12:0] RECIP_9     = 13'd7282;
   localparam int          RECIP_SHIFT = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue_mean;
      logic [PIX_W-1:0] green_mean;
      logic [PIX_W-1:0] red_mean;
      logic [POS_W-1:0] center_row;
      logic [POS_W-1:0] center_col;
      logic             frame_done;
   } rsp_type;

   // one line store entry: the pixel two rows up and the pixel one row up
   typedef struct packed {
      req_type upper;
      req_type middle;
   } line_entry_type;

   typedef struct packed {
      logic             emit;
      logic             frame_done;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } ctrl_type;

   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } sum_type;

   function automatic logic [PIX_W-1:0] mean9(input logic [SUM_W-1:0] sum);
      logic [SUM_W+13-1:0] prod;
      prod = (SUM_W+13)'(sum) * (SUM_W+13)'(RECIP_9);
      return prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
   endfunction

endpackage

>>> rtl/bb3_line_store.sv
// ----------------------------------------------------------------------------
// bb3_line_store
// Two-row line buffer in one synchronous memory, one entry per column.
// One read and one write per cycle; read data arrives in the cycle after the read.
// ----------------------------------------------------------------------------
module bb3_line_store #(
   parameter int DEPTH = 2048
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output bb3_pkg::line_entry_type       rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  bb3_pkg::line_entry_type       wr_data
);

   bb3_pkg::line_entry_type mem [DEPTH];
   bb3_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 window: six registers for the two previous columns plus the column
// arriving now, summed per channel into a registered stage.
// ----------------------------------------------------------------------------
module bb3_window (
   input  logic              clock,
   input  logic              reset,
   input  logic              s1_valid,
   input  bb3_pkg::ctrl_type s1_ctrl,
   input  bb3_pkg::req_type  top_pix,
   input  bb3_pkg::req_type  mid_pix,
   input  bb3_pkg::req_type  bot_pix,
   output logic              s2_valid,
   output bb3_pkg::ctrl_type s2_ctrl,
   output bb3_pkg::sum_type  s2_sum
);

   // [0..2] column c-2 top/mid/bot, [3..5] column c-1
   bb3_pkg::req_type  win_ff [6];
   bb3_pkg::req_type  win_in [6];
   bb3_pkg::sum_type  sum_in;
   bb3_pkg::sum_type  s2_sum_ff;
   bb3_pkg::ctrl_type s2_ctrl_ff;
   logic              s2_valid_ff;

   always_comb begin
      sum_in.blue  = bb3_pkg::SUM_W'(top_pix.blue) + bb3_pkg::SUM_W'(mid_pix.blue)
                   + bb3_pkg::SUM_W'(bot_pix.blue);
      sum_in.green = bb3_pkg::SUM_W'(top_pix.green) + bb3_pkg::SUM_W'(mid_pix.green)
                   + bb3_pkg::SUM_W'(bot_pix.green);
      sum_in.red   = bb3_pkg::SUM_W'(top_pix.red) + bb3_pkg::SUM_W'(mid_pix.red)
                   + bb3_pkg::SUM_W'(bot_pix.red);
      for (int i = 0; i < 6; i++) begin
         sum_in.blue  = sum_in.blue  + bb3_pkg::SUM_W'(win_ff[i].blue);
         sum_in.green = sum_in.green + bb3_pkg::SUM_W'(win_ff[i].green);
         sum_in.red   = sum_in.red   + bb3_pkg::SUM_W'(win_ff[i].red);
      end
   end

   // shift the window one column left
   always_comb begin
      win_in[0] = win_ff[3];
      win_in[1] = win_ff[4];
      win_in[2] = win_ff[5];
      win_in[3] = top_pix;
      win_in[4] = mid_pix;
      win_in[5] = bot_pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_valid) begin
            for (int i = 0; i < 6; i++) begin
               win_ff[i] <= win_in[i];
            end
         end
         s2_valid_ff <= s1_valid & s1_ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid) begin
         s2_sum_ff  <= sum_in;
         s2_ctrl_ff <= s1_ctrl;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_ctrl  = s2_ctrl_ff;
   assign s2_sum   = s2_sum_ff;

endmodule

>>> rtl/bb3_rsp_queue.sv
// ----------------------------------------------------------------------------
// bb3_rsp_queue
// Divides the channel sums by nine and queues finished result words
// until the consumer takes them.
// ----------------------------------------------------------------------------
module bb3_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  bb3_pkg::ctrl_type            push_ctrl,
   input  bb3_pkg::sum_type             push_sum,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bb3_pkg::rsp_type             rsp_data,
   output logic [bb3_pkg::QFILL_W-1:0]  fill
);

   bb3_pkg::rsp_type                entry_ff [bb3_pkg::QUEUE_DEPTH];
   bb3_pkg::rsp_type                entry_in;
   logic [bb3_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [bb3_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [bb3_pkg::QFILL_W-1:0]     fill_ff;
   logic                            pop;

   assign pop = rsp_valid & rsp_ready;

   always_comb begin
      entry_in.blue_mean  = bb3_pkg::mean9(push_sum.blue);
      entry_in.green_mean = bb3_pkg::mean9(push_sum.green);
      entry_in.red_mean   = bb3_pkg::mean9(push_sum.red);
      entry_in.center_row = push_ctrl.row;
      entry_in.center_col = push_ctrl.col;
      entry_in.frame_done = push_ctrl.frame_done;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   assign rsp_valid = (fill_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign fill      = fill_ff;

endmodule

>>> rtl/box_blur_3x3_rgb_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_top
// 3x3 mean blur over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock, sustained, and gives one result word per
// interior pixel, the truncated mean of its nine neighbors per channel, when
// its bottom-right neighbor arrives; border pixels give no word. A result
// passes stage s1, stage s2 and the result queue before it shows on rsp. The
// rate is set by the line store, one memory that takes one read (the column
// arriving) and one write (the column held in stage s1) in every cycle. A
// four-word result queue lets input continue while rsp is stalled; req_ready
// drops only when the queue and the two pipeline stages hold four results.
// Writing image_width or image_height restarts the frame at row 0, column 0;
// sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT. The line store needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bb3_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bb3_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WIDTH_RESET  = (640 > MAX_WIDTH)  ? MAX_WIDTH  : 640;
   localparam int HEIGHT_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
   localparam logic [CW-1:0] LAST_COL_RESET = CW'(WIDTH_RESET - 1);
   localparam logic [RW-1:0] LAST_ROW_RESET = RW'(HEIGHT_RESET - 1);

   // clamp a size to 3..max_dim and give its last index
   function automatic int unsigned last_index(input logic [bb3_pkg::CSR_DATA_W-1:0] v,
                                              input int unsigned max_dim);
      int unsigned d;
      d = 32'(v);
      if (d < 3) begin
         d = 3;
      end else if (d > max_dim) begin
         d = max_dim;
      end
      return d - 1;
   endfunction

   logic [CW-1:0]               last_col_ff, last_col_in;
   logic [RW-1:0]               last_row_ff, last_row_in;
   logic [CW-1:0]               col_count_ff, col_count_in;
   logic [RW-1:0]               row_count_ff, row_count_in;
   logic                        size_write;
   logic                        req_fire;

   logic                        s1_valid_ff;
   bb3_pkg::ctrl_type           s1_ctrl_ff, s1_ctrl_in;
   bb3_pkg::req_type            s1_pix_ff;
   logic [CW-1:0]               s1_col_ff;

   bb3_pkg::line_entry_type     line_rd;
   bb3_pkg::line_entry_type     line_wr;

   logic                        s2_valid;
   bb3_pkg::ctrl_type           s2_ctrl;
   bb3_pkg::sum_type            s2_sum;

   logic [bb3_pkg::QFILL_W-1:0] queue_fill;
   logic [bb3_pkg::QFILL_W:0]   in_flight;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid & req_ready;

   // size registers
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      size_write  = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            bb3_pkg::CSR_IMAGE_WIDTH: begin
               last_col_in = CW'(last_index(csr_data, MAX_WIDTH));
               size_write  = 1'b1;
            end
            bb3_pkg::CSR_IMAGE_HEIGHT: begin
               last_row_in = RW'(last_index(csr_data, MAX_HEIGHT));
               size_write  = 1'b1;
            end
            default: begin
               size_write = 1'b0;
            end
         endcase
      end
   end

   // raster position of the arriving pixel
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (size_write) begin
         col_count_in = '0;
         row_count_in = '0;
      end else if (req_fire) begin
         if (col_count_ff >= last_col_ff) begin
            col_count_in = '0;
            row_count_in = (row_count_ff >= last_row_ff) ? '0 : row_count_ff + 1'b1;
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff  <= LAST_COL_RESET;
         last_row_ff  <= LAST_ROW_RESET;
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= req_fire;
      end
   end

   always_comb begin
      s1_ctrl_in.emit       = (row_count_ff >= RW'(2)) && (col_count_ff >= CW'(2));
      s1_ctrl_in.frame_done = (row_count_ff >= last_row_ff) && (col_count_ff >= last_col_ff);
      s1_ctrl_in.row        = bb3_pkg::POS_W'(32'(row_count_ff) - 32'd1);
      s1_ctrl_in.col        = bb3_pkg::POS_W'(32'(col_count_ff) - 32'd1);
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_pix_ff  <= req_data;
         s1_col_ff  <= col_count_ff;
      end
   end

   // advance the column: the old middle row moves up, the new pixel moves in
   always_comb begin
      line_wr.upper  = line_rd.middle;
      line_wr.middle = s1_pix_ff;
   end

   bb3_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_count_ff),
      .rd_data (line_rd),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr)
   );

   bb3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid_ff),
      .s1_ctrl  (s1_ctrl_ff),
      .top_pix  (line_rd.upper),
      .mid_pix  (line_rd.middle),
      .bot_pix  (s1_pix_ff),
      .s2_valid (s2_valid),
      .s2_ctrl  (s2_ctrl),
      .s2_sum   (s2_sum)
   );

   bb3_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid),
      .push_ctrl (s2_ctrl),
      .push_sum  (s2_sum),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .fill      (queue_fill)
   );

   // hold input once every queue slot is spoken for
   assign in_flight = (bb3_pkg::QFILL_W+1)'(queue_fill)
                    + (bb3_pkg::QFILL_W+1)'(s1_valid_ff & s1_ctrl_ff.emit)
                    + (bb3_pkg::QFILL_W+1)'(s2_valid);
   assign req_ready = (in_flight < (bb3_pkg::QFILL_W+1)'(bb3_pkg::QUEUE_DEPTH));

endmodule

>>> rtl/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks on the box blur top level, bound to every instance.
// ----------------------------------------------------------------------------
module bb3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input bb3_pkg::rsp_type               rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input stalls only while results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a result is never on the first row or the first column
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.center_row != '0) && (rsp_data.center_col != '0))
      else $error("result on a border pixel");

endmodule

bind box_blur_3x3_rgb_top bb3_checker u_bb3_checker (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 RGB box blur: a pixel stream with random
// flow control on both sides, checked word by word against a blur predictor.
// ----------------------------------------------------------------------------
// An initial block queues image sizes and pixels: a few small directed frames
// (saturated and alternating samples, sizes below the floor, an unknown
// register index in mid frame), one wide and one tall frame, then small
// frames with random sizes and partial frames.
// The driver and the response monitor idle in random bursts; once the
// monitor holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_DIM       = 2048;
   localparam int WINDOW_TAPS   = 9;
   localparam int LONG_DIM      = 64;
   localparam int RANDOM_PIXELS = 140;
   localparam int TAIL_WORDS    = 120;   // no idling once this few remain
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 100;
   localparam int STALL_LIMIT   = 2000;

   localparam logic [bb3_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 4'd2;
   localparam logic [bb3_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 4'd15;

   typedef enum logic [0:0] {
      WORD_PIXEL,
      WORD_CSR
   } word_kind_type;

   typedef struct packed {
      word_kind_type                     kind;
      bb3_pkg::req_type                  px;
      logic [bb3_pkg::CSR_IDX_W-1:0]     idx;
      logic [bb3_pkg::CSR_DATA_W-1:0]    val;
   } stream_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   bb3_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   bb3_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [bb3_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [bb3_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   box_blur_3x3_rgb_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // blur predictor state
   bb3_pkg::req_type                upper_mem [MAX_DIM];
   bb3_pkg::req_type                middle_mem [MAX_DIM];
   bb3_pkg::req_type                win [6];
   int unsigned                     col_cnt = 0;
   int unsigned                     row_cnt = 0;
   logic [bb3_pkg::CSR_DATA_W-1:0]  width_reg = 12'd640;
   logic [bb3_pkg::CSR_DATA_W-1:0]  height_reg = 12'd480;

   stream_word_type                 stream_q [$];
   bb3_pkg::rsp_type                pending_means [$];

   int unsigned            errors = 0;
   int unsigned            pixels_sent = 0;
   int unsigned            writes_done = 0;
   int unsigned            means_seen = 0;
   int unsigned            frames_seen = 0;
   int unsigned            quiet_cycles = 0;
   int unsigned            send_gap = 0;
   int unsigned            send_rest = 0;
   int unsigned            recv_stall = 0;
   int unsigned            recv_rest = 0;
   int unsigned            hold_left = 0;
   bit                     held = 1'b0;
   int unsigned            idle_cycles = 0;

   initial begin
      for (int j = 0; j < MAX_DIM; j++) begin
         upper_mem[j] = '0;
         middle_mem[j] = '0;
      end
      for (int j = 0; j < 6; j++) win[j] = '0;
   end

   function automatic int unsigned clamp_size(logic [bb3_pkg::CSR_DATA_W-1:0] v);
      if (v < 3) return 3;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
   endfunction

   function automatic void apply_write(logic [bb3_pkg::CSR_IDX_W-1:0] idx,
                                       logic [bb3_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         bb3_pkg::CSR_IMAGE_WIDTH: begin
            width_reg = val;
            col_cnt = 0;
            row_cnt = 0;
         end
         bb3_pkg::CSR_IMAGE_HEIGHT: begin
            height_reg = val;
            col_cnt = 0;
            row_cnt = 0;
         end
         default: ;
      endcase
   endfunction

   // advance the window by one pixel; queue the mean of the pixel whose
   // bottom-right neighbor this is
   function automatic void blur_pixel(bb3_pkg::req_type px);
      int unsigned      w, h, sum_b, sum_g, sum_r, k;
      bb3_pkg::req_type top, mid;
      bb3_pkg::rsp_type res;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      top = upper_mem[col_cnt];
      mid = middle_mem[col_cnt];
      if (row_cnt >= 2 && col_cnt >= 2) begin
         sum_b = 32'(top.blue) + 32'(mid.blue) + 32'(px.blue);
         sum_g = 32'(top.green) + 32'(mid.green) + 32'(px.green);
         sum_r = 32'(top.red) + 32'(mid.red) + 32'(px.red);
         for (k = 0; k < 6; k++) begin
            sum_b += 32'(win[k].blue);
            sum_g += 32'(win[k].green);
            sum_r += 32'(win[k].red);
         end
         res.blue_mean  = 8'(sum_b / WINDOW_TAPS);
         res.green_mean = 8'(sum_g / WINDOW_TAPS);
         res.red_mean   = 8'(sum_r / WINDOW_TAPS);
         res.center_row = 11'(row_cnt - 1);
         res.center_col = 11'(col_cnt - 1);
         res.frame_done = (row_cnt + 1 >= h) && (col_cnt + 1 >= w);
         pending_means.insert(pending_means.size(), res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = px;
      upper_mem[col_cnt] = mid;
      middle_mem[col_cnt] = px;
      if (col_cnt + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
      end else begin
         col_cnt = col_cnt + 1;
      end
   endfunction

   function automatic logic [7:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic bb3_pkg::req_type rand_pixel();
      bb3_pkg::req_type p;
      p.blue = rand_sample();
      p.green = rand_sample();
      p.red = rand_sample();
      return p;
   endfunction

   function automatic logic [bb3_pkg::CSR_DATA_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0: return 12'($urandom_range(0, 2));
         1: return 12'd3;
         default: return 12'($urandom_range(4, 14));
      endcase
   endfunction

   task automatic add_pixel(bb3_pkg::req_type px);
      stream_word_type sw;
      sw = '0;
      sw.kind = WORD_PIXEL;
      sw.px = px;
      stream_q.insert(stream_q.size(), sw);
   endtask

   task automatic add_write(logic [bb3_pkg::CSR_IDX_W-1:0] idx,
                            logic [bb3_pkg::CSR_DATA_W-1:0] val);
      stream_word_type sw;
      sw = '0;
      sw.kind = WORD_CSR;
      sw.idx = idx;
      sw.val = val;
      stream_q.insert(stream_q.size(), sw);
   endtask

   task automatic flag_field(string name, int unsigned want, int unsigned got);
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
   endtask

   // driver: pixel words and register writes in queue order
   always @(posedge clock) begin : drive_words
      logic                            nv_req, nv_csr, took_px;
      bb3_pkg::req_type                nd_req;
      logic [bb3_pkg::CSR_IDX_W-1:0]   n_idx;
      logic [bb3_pkg::CSR_DATA_W-1:0]  n_val;
      stream_word_type                 sw;
      nv_req = req_valid;
      nv_csr = csr_valid;
      nd_req = req_data;
      n_idx = csr_index;
      n_val = csr_data;
      took_px = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            blur_pixel(req_data);
            pixels_sent++;
            nv_req = 1'b0;
            took_px = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
            writes_done++;
            nv_csr = 1'b0;
         end
         if (took_px || req_valid || pending_means.size() != 0)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (!nv_req && !nv_csr && stream_q.size() != 0) begin
            if (stream_q[0].kind == WORD_CSR) begin
               // write only once the block has gone quiet
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  sw = stream_q.pop_front();
                  nv_csr = 1'b1;
                  n_idx = sw.idx;
                  n_val = sw.val;
               end
            end else if (send_gap > 0) begin
               send_gap--;
            end else if (send_rest == 0 && stream_q.size() > TAIL_WORDS
                         && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 14) - 1;
               send_rest = $urandom_range(0, 40);
            end else begin
               if (send_rest > 0) send_rest--;
               sw = stream_q.pop_front();
               nv_req = 1'b1;
               nd_req = sw.px;
            end
         end
      end else begin
         nv_req = 1'b0;
         nv_csr = 1'b0;
      end
      req_valid <= nv_req;
      req_data <= nd_req;
      csr_valid <= nv_csr;
      csr_index <= n_idx;
      csr_data <= n_val;
   end

   // monitor: check result words and drive rsp_ready
   always @(posedge clock) begin : watch_means
      logic             nr;
      bb3_pkg::rsp_type want;
      nr = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            means_seen++;
            if (rsp_data.frame_done) frames_seen++;
            if (pending_means.size() == 0) begin
               $display("%0t: no result expected, got %h", $time, rsp_data);
               errors++;
            end else begin
               want = pending_means.pop_front();
               if (rsp_data.blue_mean !== want.blue_mean)
                  flag_field("blue_mean", 32'(want.blue_mean), 32'(rsp_data.blue_mean));
               if (rsp_data.green_mean !== want.green_mean)
                  flag_field("green_mean", 32'(want.green_mean), 32'(rsp_data.green_mean));
               if (rsp_data.red_mean !== want.red_mean)
                  flag_field("red_mean", 32'(want.red_mean), 32'(rsp_data.red_mean));
               if (rsp_data.center_row !== want.center_row)
                  flag_field("center_row", 32'(want.center_row), 32'(rsp_data.center_row));
               if (rsp_data.center_col !== want.center_col)
                  flag_field("center_col", 32'(want.center_col), 32'(rsp_data.center_col));
               if (rsp_data.frame_done !== want.frame_done)
                  flag_field("frame_done", 32'(want.frame_done), 32'(rsp_data.frame_done));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (!held && means_seen >= HOLD_AFTER) begin
            // long hold-off: let the result queue fill and back up the input
            held = 1'b1;
            hold_left = HOLD_CYCLES - 1;
         end else if (recv_stall > 0) begin
            recv_stall--;
         end else if (recv_rest == 0 && stream_q.size() > TAIL_WORDS
                      && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(1, 14) - 1;
            recv_rest = $urandom_range(0, 40);
         end else begin
            if (recv_rest > 0) recv_rest--;
            nr = 1'b1;
         end
      end
      rsp_ready <= nr;
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run
      int unsigned                     n, w_eff, h_eff, random_pixels, k;
      logic [bb3_pkg::CSR_DATA_W-1:0]  w_val, h_val;
      bb3_pkg::req_type                hi_px, lo_px;

      // saturated 3x3 frame
      add_write(bb3_pkg::CSR_IMAGE_WIDTH, 12'd3);
      add_write(bb3_pkg::CSR_IMAGE_HEIGHT, 12'd3);
      hi_px = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};
      repeat (9) add_pixel(hi_px);
      // sizes below the floor clamp to 3x3; alternating samples test truncation
      add_write(bb3_pkg::CSR_IMAGE_WIDTH, 12'd0);
      add_write(bb3_pkg::CSR_IMAGE_HEIGHT, 12'd2);
      hi_px = '{blue: 8'hFF, green: 8'h00, red: 8'hFF};
      lo_px = '{blue: 8'h00, green: 8'hFF, red: 8'h00};
      for (k = 0; k < 9; k++) add_pixel((k % 2 == 0) ? hi_px : lo_px);
      // unknown register in mid frame: counters must run on
      for (k = 0; k < 4; k++) add_pixel(rand_pixel());
      add_write(CSR_UNUSED_LO, 12'hFFF);
      for (k = 0; k < 5; k++) add_pixel(rand_pixel());

      // one wide frame, then one tall frame
      add_write(bb3_pkg::CSR_IMAGE_WIDTH, 12'(LONG_DIM));
      add_write(bb3_pkg::CSR_IMAGE_HEIGHT, 12'd3);
      repeat (LONG_DIM * 3) add_pixel(rand_pixel());
      add_write(bb3_pkg::CSR_IMAGE_WIDTH, 12'd3);
      add_write(bb3_pkg::CSR_IMAGE_HEIGHT, 12'(LONG_DIM));
      repeat (LONG_DIM * 3) add_pixel(rand_pixel());

      // small random frames, often cut short by the next size change
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         w_val = pick_size();
         h_val = pick_size();
         w_eff = clamp_size(w_val);
         h_eff = clamp_size(h_val);
         if ($urandom_range(0, 3) == 0)
            add_write(4'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI)),
                      12'($urandom_range(0, 4095)));
         add_write(bb3_pkg::CSR_IMAGE_WIDTH, w_val);
         add_write(bb3_pkg::CSR_IMAGE_HEIGHT, h_val);
         n = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);
         if (n > RANDOM_PIXELS - random_pixels)
            n = RANDOM_PIXELS - random_pixels;
         repeat (n) add_pixel(rand_pixel());
         random_pixels += n;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (stream_q.size() != 0 || req_valid || csr_valid || pending_means.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_means.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_means.size());
         errors++;
      end

      $display("summary: %0d pixels and %0d register writes sent, %0d means checked,",
               pixels_sent, writes_done, means_seen);
      $display("summary: %0d frames ended; sizes from below the floor up to %0d, %s %0d cycles",
               frames_seen, LONG_DIM, "result side held off once for", HOLD_CYCLES);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

>>> filelist.f
rtl/bb3_pkg.sv
rtl/bb3_line_store.sv
rtl/bb3_window.sv
rtl/bb3_rsp_queue.sv
rtl/box_blur_3x3_rgb_top.sv
rtl/bb3_checker.sv
bench/tb_top.sv
